### hdl/ldb_pkg.sv
`default_nettype none
package ldb_pkg;

	localparam int OUT_FRAC_BITS = 14;
	localparam int CW = 16;
	localparam int DW = 32;
	localparam int VW = 33;
	localparam int MW = VW;
	localparam int NW = 30;
	localparam int SW = 2 * NW + 2;
	localparam int RTW = NW + 1;
	localparam int QW = OUT_FRAC_BITS + 2;
	localparam int PW = 6;

	localparam logic [CW-1:0] ONE_FX = CW'(1 << OUT_FRAC_BITS);
	localparam logic [16:0] MIN_LENGTH_RST = 17'd655;
	localparam logic [14:0] PARALLEL_LIMIT_RST = 15'd16368;

	typedef enum logic [7:0] {
		REG_MIN_LENGTH     = 8'd0,
		REG_PARALLEL_LIMIT = 8'd1
	} ldb_reg_t;

	typedef struct packed {
		logic [2:0][CW-1:0] right;
		logic [2:0][CW-1:0] front;
		logic               dflt;
		logic               alt;
	} ldb_side_t;

endpackage
`default_nettype wire

### hdl/look_direction_basis.sv
// Orientation basis from a direction vector.
// The slave side takes one direction per beat on s_tdata: dir_x, dir_y and dir_z,
// each a signed Q15.16 word. The master side returns one beat per direction with
// the right, upward and front axes in signed Q1.14 on m_tdata, and on m_tuser the
// flags that tell whether the default direction or the alternate up axis was used.
// One direction can be accepted in every cycle while s_tready is high. Most of the
// pipeline lies in the three normalizing units, each of which takes 54 stages:
// a 31-stage square root that settles one root bit a stage and a 16-stage
// divider that settles one quotient bit a stage per component.
// The configuration channel writes min_length (index 0) and parallel_limit
// (index 1); it is always ready and is meant to be used while no beat is in flight.
// Reset clears every valid bit and restores both registers to their defaults.
// When the receiver stalls, the finished beat waits on the output register and one
// more beat is caught in a skid register; only then does s_tready fall and the
// whole pipeline hold, so that nothing is lost or repeated.
`default_nettype none
module look_direction_basis (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // dir_x, dir_y, dir_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // right_x/y/z, upward_x/y/z, front_x/y/z
	output logic [1:0]   m_tuser,   // used_default, used_alt_up
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [16:0]  cfg_data
);
	import ldb_pkg::*;

	logic [16:0] min_length_q;
	logic [14:0] parallel_limit_q;
	logic        en;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0]   d_s1 [3];
	logic signed [DW-1:0]   d_s2 [3];
	logic [2*DW-1:0]        sq_s2 [3];
	logic [33:0]            minsq_s2;
	logic signed [VW-1:0]   a_s3 [3];
	ldb_side_t              side_s3, side_s4, side_s5;
	logic signed [VW-1:0]   a_s5 [3];
	logic [DW-1:0]          mag_c [3];
	logic [2*DW+1:0]        sum_c;
	ldb_side_t              side_in_c, side_fr_c;

	logic                   ua_v, ub_v, uc_v, cr_v;
	logic signed [CW-1:0]   ua_o [3];
	logic signed [CW-1:0]   ub_o [3];
	logic signed [CW-1:0]   uc_o [3];
	logic signed [VW-1:0]   cr_a [3];
	ldb_side_t              ua_side, ub_side, uc_side, cr_side;
	logic [CW-1:0]          front_c [3];
	logic [CW-1:0]          fy_mag_c;
	logic                   alt_c;

	logic [143:0] p_data;
	logic [1:0]   p_user;
	logic         out_v_q, skid_v_q;
	logic [143:0] out_data_q, skid_data_q;
	logic [1:0]   out_user_q, skid_user_q;

	assign cfg_ready = 1'b1;
	assign en = !skid_v_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RST;
			parallel_limit_q <= PARALLEL_LIMIT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MIN_LENGTH) min_length_q <= cfg_data;
			else if (cfg_index == REG_PARALLEL_LIMIT) parallel_limit_q <= cfg_data[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= ua_v;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = d_s1[i][DW-1] ? DW'(-d_s1[i]) : DW'(d_s1[i]);
		end
		sum_c = (2*DW+2)'(sq_s2[0]) + (2*DW+2)'(sq_s2[1]) + (2*DW+2)'(sq_s2[2]);
		side_in_c = '0;
		side_in_c.dflt = (sum_c == '0) || (sum_c < (2*DW+2)'(minsq_s2));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= $signed(s_tdata[i*DW +: DW]);
				d_s2[i] <= d_s1[i];
				sq_s2[i] <= (2*DW)'(mag_c[i]) * (2*DW)'(mag_c[i]);
				a_s3[i] <= VW'(d_s2[i]);
			end
			minsq_s2 <= 34'(min_length_q) * 34'(min_length_q);
			side_s3 <= side_in_c;
		end
	end

	ldb_unit3 u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.in_a     (a_s3),
		.in_side  (side_s3),
		.out_v    (ua_v),
		.out_o    (ua_o),
		.out_side (ua_side)
	);

	always_comb begin
		if (ua_side.dflt) begin
			front_c[0] = '0;
			front_c[1] = '0;
			front_c[2] = ONE_FX;
		end else begin
			for (int i = 0; i < 3; i++) front_c[i] = ua_o[i];
		end
		fy_mag_c = front_c[1][CW-1] ? CW'(-$signed(front_c[1])) : front_c[1];
		alt_c = (fy_mag_c > CW'(parallel_limit_q)) ||
			((front_c[0] == '0) && (front_c[2] == '0));
		side_fr_c = ua_side;
		for (int i = 0; i < 3; i++) side_fr_c.front[i] = front_c[i];
		side_fr_c.alt = alt_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_fr_c;
			side_s5 <= side_s4;
			if (side_s4.alt) begin
				a_s5[0] <= -(VW'($signed(side_s4.front[1])) <<< OUT_FRAC_BITS);
				a_s5[1] <= VW'($signed(side_s4.front[0])) <<< OUT_FRAC_BITS;
				a_s5[2] <= '0;
			end else begin
				a_s5[0] <= -(VW'($signed(side_s4.front[2])) <<< OUT_FRAC_BITS);
				a_s5[1] <= '0;
				a_s5[2] <= VW'($signed(side_s4.front[0])) <<< OUT_FRAC_BITS;
			end
		end
	end

	ldb_unit3 u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s5),
		.in_a     (a_s5),
		.in_side  (side_s5),
		.out_v    (ub_v),
		.out_o    (ub_o),
		.out_side (ub_side)
	);

	ldb_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (ub_v),
		.in_r     (ub_o),
		.in_side  (ub_side),
		.out_v    (cr_v),
		.out_a    (cr_a),
		.out_side (cr_side)
	);

	ldb_unit3 u_upward (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (cr_v),
		.in_a     (cr_a),
		.in_side  (cr_side),
		.out_v    (uc_v),
		.out_o    (uc_o),
		.out_side (uc_side)
	);

	assign p_data = {uc_side.front[2], uc_side.front[1], uc_side.front[0],
		uc_o[2], uc_o[1], uc_o[0],
		uc_side.right[2], uc_side.right[1], uc_side.right[0]};
	assign p_user = {uc_side.alt, uc_side.dflt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_v_q || m_tready) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (uc_v) begin
			if (!out_v_q || m_tready) out_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_v_q || m_tready) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (uc_v) begin
			if (!out_v_q || m_tready) begin
				out_data_q <= p_data;
				out_user_q <= p_user;
			end else begin
				skid_data_q <= p_data;
				skid_user_q <= p_user;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a beat while the output register is empty");

	a_default_front: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_user_q[0]) |-> (out_data_q[143:128] == ONE_FX &&
			out_data_q[127:96] == '0))
		else $error("default direction does not give front (0,0,1)");

	a_right_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_user_q[1]) |-> (out_data_q[31:16] == '0))
		else $error("right axis has a y component with the normal up axis");

	a_right_plane_alt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_user_q[1]) |-> (out_data_q[47:32] == '0))
		else $error("right axis has a z component with the alternate up axis");

endmodule
`default_nettype wire

### hdl/ldb_unit3.sv
`default_nettype none
module ldb_unit3 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  logic signed [ldb_pkg::VW-1:0] in_a [3],
	input  ldb_pkg::ldb_side_t          in_side,
	output logic                        out_v,
	output logic signed [ldb_pkg::CW-1:0] out_o [3],
	output ldb_pkg::ldb_side_t          out_side
);
	import ldb_pkg::*;

	typedef struct packed {
		logic [SW-1:0]         n;
		logic [RTW:0]          rem;
		logic [RTW-1:0]        root;
		logic [2:0][NW-1:0]    m;
		logic [2:0]            neg;
		logic                  zero;
		ldb_side_t             side;
	} rt_t;

	typedef struct packed {
		logic [RTW-1:0]        len;
		logic [2:0][RTW:0]     r;
		logic [2:0][QW-1:0]    q;
		logic [2:0]            neg;
		logic                  zero;
		ldb_side_t             side;
	} dv_t;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [2:0][MW-1:0]  m_s1, m_s2;
	logic [2:0]          neg_s1, neg_s2, neg_s3, neg_s4;
	ldb_side_t           side_s1, side_s2, side_s3, side_s4;
	logic [PW-1:0]       pos_s2;
	logic                zero_s2, zero_s3, zero_s4;
	logic [2:0][NW-1:0]  n_s3, n_s4;
	logic [2:0][2*NW-1:0] sq_s4;
	logic [MW-1:0]       mx_c;
	logic [PW-1:0]       pos_c;
	logic [2:0][NW-1:0]  sh_c;

	logic rt_v [0:RTW];
	rt_t  rt_s [0:RTW];
	logic dv_v [0:QW];
	dv_t  dv_s [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			rt_v[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rt_v[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i] <= in_a[i][VW-1] ? MW'(-in_a[i]) : MW'(in_a[i]);
				neg_s1[i] <= in_a[i][VW-1];
			end
			side_s1 <= in_side;
		end
	end

	always_comb begin
		mx_c = m_s1[0];
		if (m_s1[1] > mx_c) mx_c = m_s1[1];
		if (m_s1[2] > mx_c) mx_c = m_s1[2];
		pos_c = '0;
		for (int b = 0; b < MW; b++) begin
			if (mx_c[b]) pos_c = PW'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= m_s1;
			neg_s2 <= neg_s1;
			side_s2 <= side_s1;
			pos_s2 <= pos_c;
			zero_s2 <= (mx_c == '0);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 > PW'(NW - 1))
				sh_c[i] = NW'(m_s2[i] >> (pos_s2 - PW'(NW - 1)));
			else
				sh_c[i] = NW'(m_s2[i] << (PW'(NW - 1) - pos_s2));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3 <= sh_c;
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= (2*NW)'(n_s3[i]) * (2*NW)'(n_s3[i]);
			end
			n_s4 <= n_s3;
			neg_s4 <= neg_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;
			rt_s[0].n <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			rt_s[0].rem <= '0;
			rt_s[0].root <= '0;
			rt_s[0].m <= n_s4;
			rt_s[0].neg <= neg_s4;
			rt_s[0].zero <= zero_s4;
			rt_s[0].side <= side_s4;
		end
	end

	for (genvar k = 0; k < RTW; k++) begin : g_root
		logic [RTW+2:0] rem_t, trial;
		rt_t            stg_c;
		assign rem_t = {rt_s[k].rem, rt_s[k].n[SW-1 -: 2]};
		assign trial = (RTW+3)'({rt_s[k].root, 2'b01});

		always_comb begin
			stg_c = rt_s[k];
			stg_c.n = rt_s[k].n << 2;
			if (rem_t >= trial) begin
				stg_c.rem = (RTW+1)'(rem_t - trial);
				stg_c.root = {rt_s[k].root[RTW-2:0], 1'b1};
			end else begin
				stg_c.rem = (RTW+1)'(rem_t);
				stg_c.root = {rt_s[k].root[RTW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[k+1] <= 1'b0;
			end else if (en) begin
				rt_v[k+1] <= rt_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k+1] <= stg_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= rt_v[RTW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].len <= rt_s[RTW].root;
			for (int i = 0; i < 3; i++) begin
				dv_s[0].r[i] <= (RTW+1)'(rt_s[RTW].m[i]);
			end
			dv_s[0].q <= '0;
			dv_s[0].neg <= rt_s[RTW].neg;
			dv_s[0].zero <= rt_s[RTW].zero;
			dv_s[0].side <= rt_s[RTW].side;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [2:0][RTW+1:0] t;
		dv_t                 stg_c;
		for (genvar i = 0; i < 3; i++) begin : g_lane
			if (j == 0) begin : g_first
				assign t[i] = (RTW+2)'(dv_s[j].r[i]);
			end else begin : g_next
				assign t[i] = {dv_s[j].r[i], 1'b0};
			end
		end

		always_comb begin
			stg_c = dv_s[j];
			for (int i = 0; i < 3; i++) begin
				if (t[i] >= (RTW+2)'(dv_s[j].len)) begin
					stg_c.r[i] = (RTW+1)'(t[i] - (RTW+2)'(dv_s[j].len));
					stg_c.q[i] = {dv_s[j].q[i][QW-2:0], 1'b1};
				end else begin
					stg_c.r[i] = (RTW+1)'(t[i]);
					stg_c.q[i] = {dv_s[j].q[i][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j+1] <= stg_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		logic [QW:0]   rq;
		logic [QW-1:0] q;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rq = ((QW+1)'(dv_s[QW].q[i]) + (QW+1)'(1)) >> 1;
				q = QW'(rq);
				if (q > QW'(ONE_FX)) q = QW'(ONE_FX);
				if (dv_s[QW].zero)
					out_o[i] <= '0;
				else if (dv_s[QW].neg[i])
					out_o[i] <= CW'(-$signed({1'b0, q}));
				else
					out_o[i] <= CW'(q);
			end
			out_side <= dv_s[QW].side;
		end
	end

endmodule
`default_nettype wire

### hdl/ldb_cross.sv
`default_nettype none
module ldb_cross (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_v,
	input  logic signed [ldb_pkg::CW-1:0] in_r [3],
	input  ldb_pkg::ldb_side_t            in_side,
	output logic                          out_v,
	output logic signed [ldb_pkg::VW-1:0] out_a [3],
	output ldb_pkg::ldb_side_t            out_side
);
	import ldb_pkg::*;

	logic                     v_s1;
	logic signed [2*CW-1:0]   p_s1 [6];
	ldb_side_t                side_s1;
	ldb_side_t                side_c;
	logic signed [CW-1:0]     f [3];

	always_comb begin
		side_c = in_side;
		for (int i = 0; i < 3; i++) begin
			f[i] = $signed(in_side.front[i]);
			side_c.right[i] = in_r[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			out_v <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= in_r[1] * f[2];
			p_s1[1] <= in_r[2] * f[1];
			p_s1[2] <= in_r[2] * f[0];
			p_s1[3] <= in_r[0] * f[2];
			p_s1[4] <= in_r[0] * f[1];
			p_s1[5] <= in_r[1] * f[0];
			side_s1 <= side_c;
			out_a[0] <= VW'(p_s1[0]) - VW'(p_s1[1]);
			out_a[1] <= VW'(p_s1[2]) - VW'(p_s1[3]);
			out_a[2] <= VW'(p_s1[4]) - VW'(p_s1[5]);
			out_side <= side_s1;
		end
	end

endmodule
`default_nettype wire

### dv/look_direction_basis_tb.sv
`default_nettype none
module look_direction_basis_tb;
	import ldb_pkg::*;

	typedef struct packed {
		logic [15:0] fz, fy, fx, uz, uy, ux, rz, ry, rx;
		logic alt, dflt;
	} basis_t;

	class basis_scoreboard;
		basis_t pending[$];
		int errors;
		int checked;
		int n_dflt;
		int n_alt;

		function void note_direction(basis_t b);
			pending.push_back(b);
			if (b.dflt)
				n_dflt++;
			if (b.alt)
				n_alt++;
		endfunction

		function void check_basis(basis_t got);
			basis_t exp_b;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $realtime, got);
				errors++;
				return;
			end
			exp_b = pending.pop_front();
			checked++;
			if (got !== exp_b) begin
				$display("%0t: mismatch expected %h actual %h", $realtime, exp_b, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [95:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [143:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_index;
	logic [16:0] cfg_data;

	logic [16:0] min_len;
	logic [14:0] par_lim;
	basis_scoreboard sb;
	bit in_quiet;
	bit out_quiet;
	int hold_cycles;
	bit long_hold_req;
	bit long_hold_done;

	look_direction_basis DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void to_unit(input longint a[3], output longint o[3]);
		logic [63:0] m[3];
		logic [63:0] mx, s, len, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = a[i] < 0 ? -a[i] : a[i];
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			o = '{0, 0, 0};
			return;
		end
		while (mx >= 64'd1 << 30) begin
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < 64'd1 << 29) begin
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
			mx <<= 1;
		end
		s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = (((m[i] << (OUT_FRAC_BITS + 1)) / len) + 1) >> 1;
			if (q > (64'd1 << OUT_FRAC_BITS))
				q = 64'd1 << OUT_FRAC_BITS;
			o[i] = a[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic void cross_prod(input longint a[3], input longint b[3],
		output longint o[3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic basis_t predict_basis(logic [95:0] dir);
		longint d[3], f[3], ax[3], t[3], r[3], u[3];
		logic [63:0] sq, m;
		longint one;
		basis_t b;
		one = longint'(1) << OUT_FRAC_BITS;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'($signed(dir[32*i +: 32]));
			m = d[i] < 0 ? -d[i] : d[i];
			sq += m * m;
		end
		b.dflt = (sq == 0) || (sq < 64'(min_len) * 64'(min_len));
		if (b.dflt)
			f = '{0, 0, one};
		else
			to_unit(d, f);
		b.alt = ((f[1] < 0 ? -f[1] : f[1]) > longint'(par_lim)) || (f[0] == 0 && f[2] == 0);
		ax = '{0, b.alt ? 0 : one, b.alt ? -one : 0};
		cross_prod(f, ax, t);
		to_unit(t, r);
		cross_prod(r, f, t);
		to_unit(t, u);
		b.rx = r[0][15:0]; b.ry = r[1][15:0]; b.rz = r[2][15:0];
		b.ux = u[0][15:0]; b.uy = u[1][15:0]; b.uz = u[2][15:0];
		b.fx = f[0][15:0]; b.fy = f[1][15:0]; b.fz = f[2][15:0];
		return b;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_basis({m_tdata, m_tuser});
	end

	always @(posedge clk) begin
		if (long_hold_req && !long_hold_done) begin
			m_tready <= 1'b0;
			hold_cycles <= 600;
			long_hold_done <= 1'b1;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (!out_quiet && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			hold_cycles <= $urandom_range(0, 9);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(ldb_reg_t idx, logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MIN_LENGTH)
			min_len = val;
		else
			par_lim = val[14:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic send_direction(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		if (!in_quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
		sb.note_direction(predict_basis({z, y, x}));
	endtask

	task automatic drain;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return 32'd0;
		endcase
	endfunction

	task automatic random_directions(int count);
		logic [31:0] x, y, z;
		for (int i = 0; i < count; i++) begin
			x = rand_comp();
			y = rand_comp();
			z = rand_comp();
			if ($urandom_range(0, 3) == 0) begin
				y = $urandom();
				x = x >>> 10;
				z = z >>> 10;
			end
			send_direction(x, y, z);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_tready = 1'b0;
		in_quiet = 0;
		out_quiet = 0;
		long_hold_req = 0;
		min_len = MIN_LENGTH_RST;
		par_lim = PARALLEL_LIMIT_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_direction(0, 0, 0);
		send_direction(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_direction(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_direction(32'h8000_0000, 0, 0);
		send_direction(0, 32'h0001_0000, 0);
		send_direction(0, 32'hffff_0000, 0);
		send_direction(0, 0, 32'h0001_0000);
		send_direction(0, 0, 32'hffff_0000);
		send_direction(654, 0, 0);
		send_direction(655, 0, 0);
		send_direction(1, 32'h0010_0000, 0);
		send_direction(32'h100, 32'h0010_0000, 32'h100);
		send_direction(1, 1, 1);
		send_direction(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
		s_tvalid <= 1'b0;
		drain();

		write_reg(REG_MIN_LENGTH, 17'd0);
		write_reg(REG_PARALLEL_LIMIT, 17'd0);
		send_direction(1, 0, 0);
		send_direction(0, 0, 1);
		send_direction(3, 5, 7);
		random_directions(50);
		drain();

		write_reg(REG_MIN_LENGTH, 17'h10000);
		write_reg(REG_PARALLEL_LIMIT, 17'h4000);
		random_directions(50);
		drain();

		write_reg(REG_MIN_LENGTH, 17'h1ffff);
		write_reg(REG_PARALLEL_LIMIT, 17'h7fff);
		random_directions(40);
		drain();

		write_reg(REG_MIN_LENGTH, 17'd300);
		write_reg(REG_PARALLEL_LIMIT, 17'd12000);
		long_hold_req = 1;
		random_directions(200);
		drain();

		write_reg(REG_MIN_LENGTH, MIN_LENGTH_RST);
		write_reg(REG_PARALLEL_LIMIT, 17'(PARALLEL_LIMIT_RST));
		in_quiet = 1;
		out_quiet = 1;
		random_directions(50);
		drain();

		$display("Checked %0d bases over five register settings: %0d short, %0d alternate up.",
			sb.checked, sb.n_dflt, sb.n_alt);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
